// ===== sv/seven_segment_frame_buffer_core_macros.svh =====
`ifndef SEVEN_SEGMENT_FRAME_BUFFER_CORE_MACROS_SVH
`define SEVEN_SEGMENT_FRAME_BUFFER_CORE_MACROS_SVH

// same-cycle implication
`define SSFB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ssfb check failed");

// next-cycle implication
`define SSFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ssfb check failed");

`endif

// ===== sv/ssfb_pkg.sv =====
package ssfb_pkg;

	localparam logic [2:0] OP_CLEAR  = 3'd0;
	localparam logic [2:0] OP_CHAR   = 3'd1;
	localparam logic [2:0] OP_SEGS   = 3'd2;
	localparam logic [2:0] OP_DOT    = 3'd3;
	localparam logic [2:0] OP_BRIGHT = 3'd4;
	localparam logic [2:0] OP_FLUSH  = 3'd5;

	localparam logic [7:0] DOT_BIT    = 8'h80;
	localparam logic [7:0] BRIGHT_CMD = 8'hE0;
	localparam logic [7:0] BRIGHT_MAX = 8'h0F;
	localparam logic [7:0] ADDR_BYTE  = 8'h00;
	localparam logic [7:0] FONT_FIRST = 8'h20;
	localparam logic [7:0] FONT_LAST  = 8'h5A;
	localparam logic [7:0] LOWER_A    = 8'h61;
	localparam logic [7:0] LOWER_Z    = 8'h7A;
	localparam logic [7:0] CASE_SHIFT = 8'h20;
	localparam int         FONT_SIZE  = 59;
	localparam logic [3:0] COUNT_RESET = 4'd8;

	localparam logic [7:0] FONT [FONT_SIZE] = '{
		8'h00, 8'h86, 8'h22, 8'h7E, 8'h6D, 8'hD2,
		8'h46, 8'h20, 8'h29, 8'h0B, 8'h21, 8'h70,
		8'h10, 8'h40, 8'h80, 8'h52, 8'h3F, 8'h06,
		8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
		8'h7F, 8'h6F, 8'h09, 8'h0D, 8'h61, 8'h48,
		8'h43, 8'hD3, 8'h5F, 8'h77, 8'h7C, 8'h39,
		8'h5E, 8'h79, 8'h71, 8'h3D, 8'h76, 8'h30,
		8'h1E, 8'h75, 8'h38, 8'h15, 8'h37, 8'h3F,
		8'h73, 8'h6B, 8'h33, 8'h6D, 8'h78, 8'h3E,
		8'h3E, 8'h2A, 8'h76, 8'h6E, 8'h5B
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DOT,
		ST_FLUSH_LO,
		ST_FLUSH_HI
	} state_t;

	function automatic logic [7:0] glyph(input logic [7:0] ch);
		logic [7:0] c;
		logic [7:0] off;
		c = ch;
		if (c >= LOWER_A && c <= LOWER_Z) begin
			c = c - CASE_SHIFT;
		end
		off = c - FONT_FIRST;
		if (c < FONT_FIRST || c > FONT_LAST) begin
			return 8'h00;
		end
		return FONT[off[5:0]];
	endfunction

endpackage

// ===== sv/ssfb_if.sv =====
interface ssfb_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [2:0]  position;
	logic [7:0]  character;
	logic        dot;
	logic [15:0] mask;
	logic [7:0]  level;

	modport source (output valid, op, position, character, dot, mask, level, input ready);
	modport sink   (input valid, op, position, character, dot, mask, level, output ready);
endinterface

interface ssfb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, out_byte, last, input ready);
	modport sink   (input valid, out_byte, last, output ready);
endinterface

interface ssfb_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// ===== sv/seven_segment_frame_buffer_core.sv =====
// Seven-segment frame buffer.
// in_ch carries one request per handshake: clear, set character, set raw
// segments, set or clear the dot, brightness, or flush. out_ch carries the
// bytes bound for the display, with last marking the final byte of a run.
// cfg_ch writes digit_count (clamped to 1..MAX_DIGITS); it is always ready.
// Set dot reads the slot from the digit memory and writes it back in the
// next cycle. Brightness loads its byte into the output register, which
// presents it in the next cycle. Flush emits 1 + 2*count bytes, one per
// cycle when the receiver keeps ready high; each slot is read from the
// memory's single read port and its two bytes are sent in turn. A request
// is taken only in the idle state, outside a flush run or set dot, and
// while the output register can load. When the receiver stalls, the
// output register holds its byte and the run waits. After reset the store
// reads all zero (per-slot valid bits), the count is 8 and no byte is
// pending.
module seven_segment_frame_buffer_core
	import ssfb_pkg::*;
#(
	parameter int MAX_DIGITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	ssfb_in_if.sink    in_ch,
	ssfb_out_if.source out_ch,
	ssfb_cfg_if.sink   cfg_ch
);

	localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam logic [3:0] MAX_CNT = 4'(MAX_DIGITS);

	logic [15:0]         mem [MAX_DIGITS];
	logic [MAX_DIGITS-1:0] valid_q;
	logic [15:0]         rd_q;
	logic                rdv_q;
	logic [3:0]          count_q;
	state_t              state_q, state_d;
	logic [AW-1:0]       idx_q, idx_d;
	logic [AW-1:0]       slot_q;
	logic                dot_q;
	logic                out_valid_q;
	logic [7:0]          out_byte_q;
	logic                out_last_q;

	logic [3:0]    n;
	logic [3:0]    slot_full;
	logic [AW-1:0] slot;
	logic          pos_ok;
	logic          accept;
	logic          out_free;
	logic          in_ready;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic          wr_en;
	logic [15:0]   wr_data;
	logic          clr_en;
	logic          out_load;
	logic [7:0]    out_byte_d;
	logic          out_last_d;
	logic [15:0]   word;
	logic          fl_last;
	logic [3:0]    lvl;

	always_comb begin
		if (count_q == 4'd0) begin
			n = 4'd1;
		end else if (count_q > MAX_CNT) begin
			n = MAX_CNT;
		end else begin
			n = count_q;
		end
	end

	assign pos_ok    = {1'b0, in_ch.position} < n;
	assign slot_full = n - 4'd1 - {1'b0, in_ch.position};
	assign slot      = slot_full[AW-1:0];
	assign out_free  = !out_valid_q || out_ch.ready;
	assign accept    = in_ch.valid && in_ready;
	assign word      = rdv_q ? rd_q : 16'h0000;
	assign fl_last   = (4'(idx_q) == (n - 4'd1));
	assign lvl       = (in_ch.level > BRIGHT_MAX) ? BRIGHT_MAX[3:0] : in_ch.level[3:0];

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		in_ready   = 1'b0;
		rd_addr    = idx_q;
		wr_addr    = slot;
		wr_en      = 1'b0;
		wr_data    = 16'h0000;
		clr_en     = 1'b0;
		out_load   = 1'b0;
		out_byte_d = 8'h00;
		out_last_d = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = out_free;
				rd_addr  = (in_ch.op == OP_FLUSH) ? '0 : slot;
				if (accept) begin
					case (in_ch.op)
						OP_CLEAR: begin
							clr_en = 1'b1;
						end
						OP_CHAR: begin
							wr_en   = pos_ok;
							wr_data = {8'h00, glyph(in_ch.character) |
								(in_ch.dot ? DOT_BIT : 8'h00)};
						end
						OP_SEGS: begin
							wr_en   = pos_ok;
							wr_data = in_ch.mask;
						end
						OP_DOT: begin
							if (pos_ok) begin
								state_d = ST_DOT;
							end
						end
						OP_BRIGHT: begin
							out_load   = 1'b1;
							out_byte_d = BRIGHT_CMD | {4'h0, lvl};
							out_last_d = 1'b1;
						end
						OP_FLUSH: begin
							out_load   = 1'b1;
							out_byte_d = ADDR_BYTE;
							idx_d      = '0;
							state_d    = ST_FLUSH_LO;
						end
						default: begin
						end
					endcase
				end
			end
			ST_DOT: begin
				rd_addr = slot_q;
				wr_addr = slot_q;
				wr_en   = 1'b1;
				wr_data = {word[15:8], dot_q, word[6:0]};
				state_d = ST_IDLE;
			end
			ST_FLUSH_LO: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_byte_d = word[7:0];
					state_d    = ST_FLUSH_HI;
				end
			end
			ST_FLUSH_HI: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_byte_d = word[15:8];
					out_last_d = fl_last;
					if (fl_last) begin
						state_d = ST_IDLE;
					end else begin
						idx_d   = AW'(idx_q + 1'b1);
						rd_addr = idx_d;
						state_d = ST_FLUSH_LO;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_ch.ready  = in_ready;
	assign cfg_ch.ready = 1'b1;
	assign out_ch.valid    = out_valid_q;
	assign out_ch.out_byte = out_byte_q;
	assign out_ch.last     = out_last_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q  <= mem[rd_addr];
		rdv_q <= valid_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q <= slot;
			dot_q  <= in_ch.dot;
		end
		if (out_load) begin
			out_byte_q <= out_byte_d;
			out_last_q <= out_last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			count_q     <= COUNT_RESET;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (cfg_ch.valid) begin
				count_q <= cfg_ch.data;
			end
			for (int i = 0; i < MAX_DIGITS; i++) begin
				if (clr_en && (4'(i) < n)) begin
					valid_q[i] <= 1'b0;
				end else if (wr_en && (wr_addr == AW'(i))) begin
					valid_q[i] <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/ssfb_checker.sv =====
`include "seven_segment_frame_buffer_core_macros.svh"

module ssfb_checker
	import ssfb_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [2:0] in_op,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_last
);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	`SSFB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_byte) && $stable(out_last))
	`SSFB_ASSERT_NOW(a_no_overrun, clk, arst_n, in_acc, !out_valid || out_ready)
	`SSFB_ASSERT_NEXT(a_bright, clk, arst_n, in_acc && in_op == OP_BRIGHT,
		out_valid && out_last && out_byte[7:4] == BRIGHT_CMD[7:4])
	`SSFB_ASSERT_NEXT(a_flush_head, clk, arst_n, in_acc && in_op == OP_FLUSH,
		out_valid && !out_last && out_byte == ADDR_BYTE && !in_ready)

endmodule

bind seven_segment_frame_buffer_core ssfb_checker u_ssfb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_op     (in_ch.op),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_byte  (out_ch.out_byte),
	.out_last  (out_ch.last)
);
